/* hw/rtl/olid_pkg.sv */
// Package for the ordered list: sizes, request and result item types, codes.
// Used by olid_cell, olid_ctrl and ordered_list_insert_delete. No dependencies.
package olid_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int MODE_W   = 3;
  localparam int VAL_W    = 32;
  localparam int POS_W    = 5;
  localparam int STAT_W   = 2;
  localparam int OCC_W    = 5;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT_AT    = 3'd0,
    MODE_INSERT_REAR  = 3'd1,
    MODE_DELETE_FRONT = 3'd2,
    MODE_DELETE_REAR  = 3'd3,
    MODE_READ         = 3'd4
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2,
    STATUS_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] read_value;
    logic [OCC_W-1:0]        occupancy;
  } rsp_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic             insert;
    logic             shift_down;
    logic [IDX_W-1:0] ins_pos;
  } cell_ctrl_t;

endpackage

/* hw/rtl/olid_cell.sv */
// One storage cell of the list chain: holds a single entry.
// Depends on olid_pkg.
module olid_cell (
  input  logic                      clk,
  input  olid_pkg::cell_ctrl_t      ctrl,
  input  logic [olid_pkg::IDX_W-1:0] my_index,
  input  logic [olid_pkg::VAL_W-1:0] value,
  input  logic [olid_pkg::VAL_W-1:0] left_data,
  input  logic [olid_pkg::VAL_W-1:0] right_data,
  output logic [olid_pkg::VAL_W-1:0] data
);
  import olid_pkg::*;

  // Cells above the insert point take their lower neighbour's entry; on a
  // front delete every cell takes its upper neighbour's entry.
  always_ff @(posedge clk) begin
    priority if (ctrl.insert && (my_index == ctrl.ins_pos)) begin
      data <= value;
    end else if (ctrl.insert && (my_index > ctrl.ins_pos)) begin
      data <= left_data;
    end else if (ctrl.shift_down) begin
      data <= right_data;
    end else begin
      data <= data;
    end
  end

endmodule

/* hw/rtl/olid_ctrl.sv */
// Request decoder and occupancy counter for the ordered list.
// Depends on olid_pkg.
module olid_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  olid_pkg::req_t              req,
  output olid_pkg::cell_ctrl_t        ctrl,
  output logic [olid_pkg::STAT_W-1:0] status,
  output logic                        read_ok,
  output logic [olid_pkg::IDX_W-1:0]  rd_idx,
  output logic [olid_pkg::CNT_W-1:0]  count_next
);
  import olid_pkg::*;

  logic [CNT_W-1:0] count;
  logic [CMP_W-1:0] cmp_pos;
  logic [CMP_W-1:0] cmp_cnt;
  logic [CMP_W-1:0] ins_where;
  logic             full;
  logic             empty;

  assign cmp_pos = CMP_W'(req.position);
  assign cmp_cnt = CMP_W'(count);
  assign full    = (count == CNT_W'(CAPACITY));
  assign empty   = (count == '0);
  assign rd_idx  = cmp_pos[IDX_W-1:0];

  always_comb begin
    ctrl       = '0;
    status     = STATUS_OK;
    read_ok    = 1'b0;
    count_next = count;
    ins_where  = (req.mode == MODE_INSERT_REAR) ? cmp_cnt : cmp_pos;
    unique case (req.mode)
      MODE_INSERT_AT, MODE_INSERT_REAR: begin
        priority if (full) begin
          status = STATUS_FULL;
        end else if (ins_where > cmp_cnt) begin
          status = STATUS_RANGE;
        end else begin
          ctrl.insert  = accept;
          ctrl.ins_pos = ins_where[IDX_W-1:0];
          count_next   = count + 1'b1;
        end
      end
      MODE_DELETE_FRONT, MODE_DELETE_REAR: begin
        if (empty) begin
          status = STATUS_EMPTY;
        end else begin
          ctrl.shift_down = accept && (req.mode == MODE_DELETE_FRONT);
          count_next      = count - 1'b1;
        end
      end
      MODE_READ: begin
        priority if (empty) begin
          status = STATUS_EMPTY;
        end else if (cmp_pos >= cmp_cnt) begin
          status = STATUS_RANGE;
        end else begin
          read_ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

endmodule

/* hw/rtl/ordered_list_insert_delete.sv */
// Top level of the ordered list: decoder, chain of entry cells, result register.
// Depends on olid_pkg, olid_ctrl and olid_cell.
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+-----------------------------------
//  request  | start, busy          | request (mode, value, position)
//  result   | done (one-cycle)     | result (status, read_value, occupancy)
//
// One item per cycle: busy stays low and the cells update in the same edge
// that accepts the item. The result item appears on the cycle after the
// item is accepted; done marks that cycle only. Reset empties the list
// at once; the receiver cannot stall, so nothing waits on the result side.
module ordered_list_insert_delete (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  olid_pkg::req_t   request,
  output logic             done,
  output olid_pkg::rsp_t   result
);
  import olid_pkg::*;

  logic                accept;
  cell_ctrl_t          ctrl;
  logic [STAT_W-1:0]   status;
  logic                read_ok;
  logic [IDX_W-1:0]    rd_idx;
  logic [CNT_W-1:0]    count_next;
  logic [VAL_W-1:0]    entry_q [CAPACITY];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  olid_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .req        (request),
    .ctrl       (ctrl),
    .status     (status),
    .read_ok    (read_ok),
    .rd_idx     (rd_idx),
    .count_next (count_next)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VAL_W-1:0] left_data;
    logic [VAL_W-1:0] right_data;
    if (i == 0) begin : g_first
      assign left_data = '0;
    end else begin : g_left
      assign left_data = entry_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_right
      assign right_data = entry_q[i+1];
    end
    olid_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .my_index   (IDX_W'(i)),
      .value      (request.value),
      .left_data  (left_data),
      .right_data (right_data),
      .data       (entry_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.status     <= status;
      result.read_value <= read_ok ? entry_q[rd_idx] : '0;
      result.occupancy  <= OCC_W'(count_next);
    end
  end

`ifndef SYNTH
  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start));
  a_occupancy_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.occupancy <= OCC_W'(CAPACITY)));
  a_full_means_capacity: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == STATUS_FULL)) |-> (result.occupancy == OCC_W'(CAPACITY)));
  a_empty_means_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == STATUS_EMPTY)) |-> (result.occupancy == '0));
`endif

endmodule

/* test/tb_ordered_list_insert_delete.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the ordered list: directed corner items, then random phases.
// Depends on olid_pkg and ordered_list_insert_delete; a scoreboard class predicts each result.

module tb_ordered_list_insert_delete;
  import olid_pkg::*;

  localparam int N_RANDOM   = 1650;
  localparam int PAUSE_AT   = 1000;
  localparam int CALM_FROM  = 500;
  localparam int CALM_TO    = 750;
  localparam int STALL_MAX  = 1000;
  localparam int SETTLE     = 4;
  localparam int PH_FILL    = 0;
  localparam int PH_DRAIN   = 1;
  localparam int PH_MIX     = 2;
  localparam int POS_TOP    = 2**POS_W - 1;
  localparam int MODE_TOP   = 2**MODE_W - 1;

  // Tracks the list contents and holds the results still owed by the block.
  class list_scoreboard;
    logic signed [VAL_W-1:0] slots [CAPACITY];
    int unsigned fill;
    rsp_t awaited [$];
    int unsigned mismatches;

    function new();
      fill = 0;
      mismatches = 0;
    endfunction

    function status_e place(int unsigned where, logic signed [VAL_W-1:0] v);
      if (fill >= CAPACITY) return STATUS_FULL;
      if (where > fill) return STATUS_RANGE;
      for (int k = fill; k > where; k--) slots[k] = slots[k-1];
      slots[where] = v;
      fill++;
      return STATUS_OK;
    endfunction

    function void note_request(req_t r);
      rsp_t e;
      e.status = STATUS_OK;
      e.read_value = '0;
      case (r.mode)
        MODE_INSERT_AT: e.status = place(r.position, r.value);
        MODE_INSERT_REAR: e.status = place(fill, r.value);
        MODE_DELETE_FRONT: begin
          if (fill == 0) e.status = STATUS_EMPTY;
          else begin
            for (int k = 0; k + 1 < fill; k++) slots[k] = slots[k+1];
            fill--;
          end
        end
        MODE_DELETE_REAR: begin
          if (fill == 0) e.status = STATUS_EMPTY;
          else fill--;
        end
        MODE_READ: begin
          if (fill == 0) e.status = STATUS_EMPTY;
          else if (r.position >= fill) e.status = STATUS_RANGE;
          else e.read_value = slots[r.position];
        end
        default: ;
      endcase
      e.occupancy = OCC_W'(fill);
      awaited.push_back(e);
    endfunction

    function void check_result(rsp_t got);
      rsp_t e;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with none outstanding: status %0d value %0d count %0d",
                   $time, got.status, got.read_value, got.occupancy);
        return;
      end
      e = awaited.pop_front();
      if (got.status !== e.status || got.read_value !== e.read_value ||
          got.occupancy !== e.occupancy) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch: status %0d/%0d value %0d/%0d count %0d/%0d (exp/got)",
                   $time, e.status, got.status, e.read_value, got.read_value,
                   e.occupancy, got.occupancy);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic done;
  req_t request;
  rsp_t result;

  list_scoreboard tracker;
  int stall_cycles;

  ordered_list_insert_delete i_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic req_t build_req(logic [MODE_W-1:0] m, logic signed [VAL_W-1:0] v,
                                     logic [POS_W-1:0] p);
    req_t r;
    r.mode = m;
    r.value = v;
    r.position = p;
    return r;
  endfunction

  // Each phase leans towards filling, draining or an even mix, so both full and
  // empty lists are reached many times.
  function automatic req_t random_req(int phase);
    int pick;
    int ins_lim;
    int rd_lim;
    int del_lim;
    logic [MODE_W-1:0] m;
    logic signed [VAL_W-1:0] v;
    logic [POS_W-1:0] p;
    pick = $urandom_range(99);
    case (phase)
      PH_FILL: begin
        ins_lim = 70; rd_lim = 85; del_lim = 96;
      end
      PH_DRAIN: begin
        ins_lim = 15; rd_lim = 32; del_lim = 95;
      end
      default: begin
        ins_lim = 36; rd_lim = 60; del_lim = 94;
      end
    endcase
    if (pick < ins_lim) m = $urandom_range(1) ? MODE_INSERT_AT : MODE_INSERT_REAR;
    else if (pick < rd_lim) m = MODE_READ;
    else if (pick < del_lim) m = $urandom_range(1) ? MODE_DELETE_FRONT : MODE_DELETE_REAR;
    else m = MODE_W'($urandom_range(MODE_TOP, MODE_READ + 1));

    case ($urandom_range(19))
      0: v = {1'b1, {(VAL_W-1){1'b0}}};
      1: v = {1'b0, {(VAL_W-1){1'b1}}};
      2: v = '0;
      3: v = '1;
      default: v = $urandom;
    endcase

    if (m == MODE_INSERT_AT && $urandom_range(9) < 8)
      p = POS_W'($urandom_range(tracker.fill));
    else if (m == MODE_READ && tracker.fill > 0 && $urandom_range(9) < 8)
      p = POS_W'($urandom_range(tracker.fill - 1));
    else
      p = POS_W'($urandom_range(POS_TOP));
    return build_req(m, v, p);
  endfunction

  // Offers one item and returns at the edge that accepts it; start is left high.
  task automatic send_item(req_t r, bit may_idle);
    while (may_idle && $urandom_range(99) < 28) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    tracker.note_request(r);
  endtask

  task automatic wait_drained();
    while (tracker.awaited.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && done) tracker.check_result(result);
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_MAX) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int phase;
    int len;
    int n;
    tracker = new();
    stall_cycles = 0;
    rst <= 1'b1;
    start <= 1'b0;
    request <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Empty list, bad insert position, extreme values, middle insert, append
    // through a position equal to the count, reads in and out of range.
    send_item(build_req(MODE_READ, '0, '0), 1'b0);
    send_item(build_req(MODE_DELETE_FRONT, '0, '0), 1'b0);
    send_item(build_req(MODE_DELETE_REAR, '0, '0), 1'b0);
    send_item(build_req(MODE_INSERT_AT, 32'sd5, 5'd3), 1'b0);
    send_item(build_req(MODE_INSERT_AT, {1'b0, {(VAL_W-1){1'b1}}}, '0), 1'b0);
    send_item(build_req(MODE_INSERT_REAR, {1'b1, {(VAL_W-1){1'b0}}}, '1), 1'b0);
    send_item(build_req(MODE_INSERT_AT, '1, 5'd1), 1'b0);
    send_item(build_req(MODE_INSERT_AT, '0, 5'd3), 1'b0);
    for (int i = 0; i < 5; i++)
      send_item(build_req(MODE_READ, '0, POS_W'(i)), 1'b0);
    send_item(build_req(MODE_READ, '0, '1), 1'b0);
    for (int m = MODE_READ + 1; m <= MODE_TOP; m++)
      send_item(build_req(MODE_W'(m), $urandom, POS_W'($urandom_range(POS_TOP))), 1'b0);
    send_item(build_req(MODE_DELETE_FRONT, '0, '0), 1'b0);
    send_item(build_req(MODE_DELETE_REAR, '0, '0), 1'b0);
    send_item(build_req(MODE_READ, '0, 5'd1), 1'b0);

    n = 0;
    while (n < N_RANDOM) begin
      phase = $urandom_range(PH_MIX);
      len = $urandom_range(80, 30);
      for (int j = 0; j < len && n < N_RANDOM; j++) begin
        if (n == PAUSE_AT) begin
          start <= 1'b0;
          wait_drained();
        end
        send_item(random_req(phase), !(n >= CALM_FROM && n < CALM_TO));
        n++;
      end
    end
    start <= 1'b0;

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.awaited.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
